@@ rtl/rgb_to_yuyv_converter_defines.svh @@
// ----------------------------------------------------------------------------
// rgb_to_yuyv_converter assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUYV_CONVERTER_DEFINES_SVH
`define RGB_TO_YUYV_CONVERTER_DEFINES_SVH

// same-cycle implication
`define RYC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RYC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ryc_pkg.sv @@
// ----------------------------------------------------------------------------
// ryc_pkg
// shared widths, reset values, register indexes and types of the converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ryc_pkg;

    localparam int MAX_PAIRS_DEFAULT  = 512;
    localparam int MAX_ROWS_DEFAULT   = 1024;
    localparam int COEFF_FRAC_DEFAULT = 14;

    localparam int PIX_W        = 8;
    localparam int PAIRS_REG_W  = 10;
    localparam int ROWS_REG_W   = 11;
    localparam int COEFF_W      = 16;
    localparam int ROW_OUT_W    = 10;
    localparam int PAIR_OUT_W   = 9;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int CHROMA_OFFSET = 128;
    localparam int QUEUE_DEPTH  = 4;

    localparam int PAIRS_RESET       = 320;
    localparam int ROWS_RESET        = 480;
    localparam int LUMA_RED_RESET    = 4898;
    localparam int LUMA_GREEN_RESET  = 9617;
    localparam int LUMA_BLUE_RESET   = 1867;
    localparam int BLUE_DIFF_RESET   = 9246;
    localparam int RED_DIFF_RESET    = 11686;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PAIRS_PER_ROW,
        REG_ROWS_PER_FRAME,
        REG_LUMA_RED,
        REG_LUMA_GREEN,
        REG_LUMA_BLUE,
        REG_BLUE_DIFF,
        REG_RED_DIFF
    } cfg_index_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] luma_red;
        logic signed [COEFF_W-1:0] luma_green;
        logic signed [COEFF_W-1:0] luma_blue;
        logic signed [COEFF_W-1:0] blue_diff;
        logic signed [COEFF_W-1:0] red_diff;
    } coeff_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t                  first;
        rgb_t                  second;
        logic [ROW_OUT_W-1:0]  dest_row;
        logic [PAIR_OUT_W-1:0] dest_pair;
        logic                  frame_end;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

@@ rtl/ryc_pixel_if.sv @@
// ----------------------------------------------------------------------------
// ryc_pixel_if
// rgb pixel pair channel, one pair per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ryc_pixel_if;
    logic                    valid;
    logic                    ready;
    logic [ryc_pkg::PIX_W-1:0] red_first;
    logic [ryc_pkg::PIX_W-1:0] green_first;
    logic [ryc_pkg::PIX_W-1:0] blue_first;
    logic [ryc_pkg::PIX_W-1:0] red_second;
    logic [ryc_pkg::PIX_W-1:0] green_second;
    logic [ryc_pkg::PIX_W-1:0] blue_second;

    modport source (
        output valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second,
        input  ready
    );

    modport sink (
        input  valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second,
        output ready
    );
endinterface

@@ rtl/ryc_word_if.sv @@
// ----------------------------------------------------------------------------
// ryc_word_if
// yuyv word channel with frame position, one word per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ryc_word_if;
    logic                           valid;
    logic                           ready;
    logic [ryc_pkg::PIX_W-1:0]      luma_first;
    logic [ryc_pkg::PIX_W-1:0]      chroma_blue;
    logic [ryc_pkg::PIX_W-1:0]      luma_second;
    logic [ryc_pkg::PIX_W-1:0]      chroma_red;
    logic [ryc_pkg::ROW_OUT_W-1:0]  dest_row;
    logic [ryc_pkg::PAIR_OUT_W-1:0] dest_pair;
    logic                           frame_end;

    modport source (
        output valid, luma_first, chroma_blue, luma_second, chroma_red,
               dest_row, dest_pair, frame_end,
        input  ready
    );

    modport sink (
        input  valid, luma_first, chroma_blue, luma_second, chroma_red,
               dest_row, dest_pair, frame_end,
        output ready
    );
endinterface

@@ rtl/ryc_front.sv @@
// ----------------------------------------------------------------------------
// ryc_front
// config registers, frame position counters, tags each accepted pair
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ryc_front #(
    parameter int MAX_PAIRS_PER_ROW = ryc_pkg::MAX_PAIRS_DEFAULT,
    parameter int MAX_ROWS          = ryc_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ryc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ryc_pkg::CFG_DATA_W-1:0]  cfg_data,
    ryc_pixel_if.sink                       pixel_in,
    input  ryc_pkg::queue_status_t          q_status,
    output logic                            push,
    output ryc_pkg::job_t                   push_job,
    output ryc_pkg::coeff_t                 coeff
);

    localparam int PAIR_W  = $clog2(MAX_PAIRS_PER_ROW);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int PMAX_W  = $clog2(MAX_PAIRS_PER_ROW + 1);
    localparam int RMAX_W  = $clog2(MAX_ROWS + 1);
    localparam int PL_W    = (ryc_pkg::PAIRS_REG_W > PMAX_W) ? ryc_pkg::PAIRS_REG_W : PMAX_W;
    localparam int RL_W    = (ryc_pkg::ROWS_REG_W > RMAX_W) ? ryc_pkg::ROWS_REG_W : RMAX_W;

    logic [ryc_pkg::PAIRS_REG_W-1:0] pairs_reg;
    logic [ryc_pkg::ROWS_REG_W-1:0]  rows_reg;
    ryc_pkg::coeff_t                 coeff_reg;

    logic [PAIR_W-1:0] pair_cnt_reg, pair_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg,  row_cnt_next;

    logic [PL_W-1:0] pair_lim, pair_last;
    logic [RL_W-1:0] row_lim,  row_last_pos, dest_row_full;
    logic            row_last, frame_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg            <= ryc_pkg::PAIRS_REG_W'(ryc_pkg::PAIRS_RESET);
            rows_reg             <= ryc_pkg::ROWS_REG_W'(ryc_pkg::ROWS_RESET);
            coeff_reg.luma_red   <= ryc_pkg::COEFF_W'(ryc_pkg::LUMA_RED_RESET);
            coeff_reg.luma_green <= ryc_pkg::COEFF_W'(ryc_pkg::LUMA_GREEN_RESET);
            coeff_reg.luma_blue  <= ryc_pkg::COEFF_W'(ryc_pkg::LUMA_BLUE_RESET);
            coeff_reg.blue_diff  <= ryc_pkg::COEFF_W'(ryc_pkg::BLUE_DIFF_RESET);
            coeff_reg.red_diff   <= ryc_pkg::COEFF_W'(ryc_pkg::RED_DIFF_RESET);
        end
        else if (cfg_wr_en)
        begin
            case (ryc_pkg::cfg_index_t'(cfg_index))
                ryc_pkg::REG_PAIRS_PER_ROW:  pairs_reg <= cfg_data[ryc_pkg::PAIRS_REG_W-1:0];
                ryc_pkg::REG_ROWS_PER_FRAME: rows_reg  <= cfg_data[ryc_pkg::ROWS_REG_W-1:0];
                ryc_pkg::REG_LUMA_RED:       coeff_reg.luma_red   <= cfg_data;
                ryc_pkg::REG_LUMA_GREEN:     coeff_reg.luma_green <= cfg_data;
                ryc_pkg::REG_LUMA_BLUE:      coeff_reg.luma_blue  <= cfg_data;
                ryc_pkg::REG_BLUE_DIFF:      coeff_reg.blue_diff  <= cfg_data;
                ryc_pkg::REG_RED_DIFF:       coeff_reg.red_diff   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign coeff = coeff_reg;

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (pairs_reg == '0)
            pair_lim = PL_W'(1);
        else if (PL_W'(pairs_reg) > PL_W'(MAX_PAIRS_PER_ROW))
            pair_lim = PL_W'(MAX_PAIRS_PER_ROW);
        else
            pair_lim = PL_W'(pairs_reg);

        if (rows_reg == '0)
            row_lim = RL_W'(1);
        else if (RL_W'(rows_reg) > RL_W'(MAX_ROWS))
            row_lim = RL_W'(MAX_ROWS);
        else
            row_lim = RL_W'(rows_reg);
    end

    assign pair_last     = pair_lim - PL_W'(1);
    assign row_last_pos  = row_lim - RL_W'(1);
    assign row_last      = PL_W'(pair_cnt_reg) >= pair_last;
    assign frame_last    = RL_W'(row_cnt_reg) >= row_last_pos;
    assign dest_row_full = frame_last ? '0 : (row_last_pos - RL_W'(row_cnt_reg));

    assign pixel_in.ready = !q_status.full;
    assign push           = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        push_job.first.red     = pixel_in.red_first;
        push_job.first.green   = pixel_in.green_first;
        push_job.first.blue    = pixel_in.blue_first;
        push_job.second.red    = pixel_in.red_second;
        push_job.second.green  = pixel_in.green_second;
        push_job.second.blue   = pixel_in.blue_second;
        push_job.dest_row      = ryc_pkg::ROW_OUT_W'(dest_row_full);
        push_job.dest_pair     = ryc_pkg::PAIR_OUT_W'(pair_cnt_reg);
        push_job.frame_end     = row_last && frame_last;
    end

    always_comb
    begin
        pair_cnt_next = pair_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        if (push)
        begin
            if (row_last)
            begin
                pair_cnt_next = '0;
                row_cnt_next  = frame_last ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
                pair_cnt_next = pair_cnt_reg + PAIR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_cnt_reg <= '0;
            row_cnt_reg  <= '0;
        end
        else
        begin
            pair_cnt_reg <= pair_cnt_next;
            row_cnt_reg  <= row_cnt_next;
        end
    end

endmodule

@@ rtl/ryc_queue.sv @@
// ----------------------------------------------------------------------------
// ryc_queue
// short fifo of tagged pairs between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ryc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ryc_pkg::job_t          push_job,
    input  logic                   pop,
    output ryc_pkg::job_t          pop_job,
    output ryc_pkg::queue_status_t q_status
);

    localparam int DEPTH = ryc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ryc_pkg::job_t slot_reg [DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign pop_job        = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        if (pop)
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[tail_reg] <= push_job;
    end

endmodule

@@ rtl/ryc_back.sv @@
// ----------------------------------------------------------------------------
// ryc_back
// four stage color math pipeline, luma products to clamped yuyv word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ryc_back #(
    parameter int COEFF_FRACTION_BITS = ryc_pkg::COEFF_FRAC_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ryc_pkg::coeff_t        coeff,
    input  ryc_pkg::queue_status_t q_status,
    output logic                   pop,
    input  ryc_pkg::job_t          pop_job,
    ryc_word_if.source             word_out
);

    localparam int F    = COEFF_FRACTION_BITS;
    localparam int LP_W = ryc_pkg::PIX_W + ryc_pkg::COEFF_W + 1;
    localparam int LS_W = LP_W + 2;
    localparam int Y_W  = LS_W - F;
    localparam int D_W  = Y_W + 1;
    localparam int CP_W = D_W + ryc_pkg::COEFF_W;
    localparam int CS_W = CP_W + 1;
    localparam int CH_W = CS_W - F;

    localparam int PW = ryc_pkg::PIX_W;

    function automatic logic [PW-1:0] clamp_y(input logic signed [Y_W-1:0] v);
        if (v < 0)
            return '0;
        else if (v > 255)
            return '1;
        else
            return v[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] clamp_c(input logic signed [CH_W-1:0] v);
        if (v < 0)
            return '0;
        else if (v > 255)
            return '1;
        else
            return v[PW-1:0];
    endfunction

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    ryc_pkg::job_t job1_reg, job2_reg, job3_reg;

    // stage 1: luma products
    logic signed [LP_W-1:0] pr0_reg, pg0_reg, pb0_reg, pr1_reg, pg1_reg, pb1_reg;
    // stage 2: unclamped luma
    logic signed [Y_W-1:0]  y0_reg, y1_reg;
    // stage 3: chroma products and clamped luma
    logic signed [CP_W-1:0] pu0_reg, pu1_reg, pv0_reg, pv1_reg;
    logic [PW-1:0]          ly0_reg, ly1_reg;
    // stage 4: output word
    logic [PW-1:0]          out_y0_reg, out_u_reg, out_y1_reg, out_v_reg;
    logic [ryc_pkg::ROW_OUT_W-1:0]  out_row_reg;
    logic [ryc_pkg::PAIR_OUT_W-1:0] out_pair_reg;
    logic                           out_end_reg;

    logic signed [LS_W-1:0] sum0, sum1;
    logic signed [D_W-1:0]  db0, db1, dr0, dr1;
    logic signed [CS_W-1:0] su, sv;
    logic signed [CH_W-1:0] ch_u, ch_v;

    assign en  = !v4_reg || word_out.ready;
    assign pop = en && !q_status.empty;

    assign sum0 = LS_W'(pr0_reg) + LS_W'(pg0_reg) + LS_W'(pb0_reg);
    assign sum1 = LS_W'(pr1_reg) + LS_W'(pg1_reg) + LS_W'(pb1_reg);

    assign db0 = $signed(D_W'(job2_reg.first.blue))  - D_W'(y0_reg);
    assign db1 = $signed(D_W'(job2_reg.second.blue)) - D_W'(y1_reg);
    assign dr0 = $signed(D_W'(job2_reg.first.red))   - D_W'(y0_reg);
    assign dr1 = $signed(D_W'(job2_reg.second.red))  - D_W'(y1_reg);

    assign su   = CS_W'(pu0_reg) + CS_W'(pu1_reg);
    assign sv   = CS_W'(pv0_reg) + CS_W'(pv1_reg);
    assign ch_u = CH_W'(su >>> (F + 1)) + CH_W'(ryc_pkg::CHROMA_OFFSET);
    assign ch_v = CH_W'(sv >>> (F + 1)) + CH_W'(ryc_pkg::CHROMA_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job1_reg <= pop_job;
            pr0_reg  <= $signed(LP_W'(pop_job.first.red))    * LP_W'($signed(coeff.luma_red));
            pg0_reg  <= $signed(LP_W'(pop_job.first.green))  * LP_W'($signed(coeff.luma_green));
            pb0_reg  <= $signed(LP_W'(pop_job.first.blue))   * LP_W'($signed(coeff.luma_blue));
            pr1_reg  <= $signed(LP_W'(pop_job.second.red))   * LP_W'($signed(coeff.luma_red));
            pg1_reg  <= $signed(LP_W'(pop_job.second.green)) * LP_W'($signed(coeff.luma_green));
            pb1_reg  <= $signed(LP_W'(pop_job.second.blue))  * LP_W'($signed(coeff.luma_blue));

            job2_reg <= job1_reg;
            y0_reg   <= Y_W'(sum0 >>> F);
            y1_reg   <= Y_W'(sum1 >>> F);

            job3_reg <= job2_reg;
            ly0_reg  <= clamp_y(y0_reg);
            ly1_reg  <= clamp_y(y1_reg);
            pu0_reg  <= CP_W'(db0) * CP_W'($signed(coeff.blue_diff));
            pu1_reg  <= CP_W'(db1) * CP_W'($signed(coeff.blue_diff));
            pv0_reg  <= CP_W'(dr0) * CP_W'($signed(coeff.red_diff));
            pv1_reg  <= CP_W'(dr1) * CP_W'($signed(coeff.red_diff));

            out_y0_reg   <= ly0_reg;
            out_y1_reg   <= ly1_reg;
            out_u_reg    <= clamp_c(ch_u);
            out_v_reg    <= clamp_c(ch_v);
            out_row_reg  <= job3_reg.dest_row;
            out_pair_reg <= job3_reg.dest_pair;
            out_end_reg  <= job3_reg.frame_end;
        end
    end

    assign word_out.valid       = v4_reg;
    assign word_out.luma_first  = out_y0_reg;
    assign word_out.chroma_blue = out_u_reg;
    assign word_out.luma_second = out_y1_reg;
    assign word_out.chroma_red  = out_v_reg;
    assign word_out.dest_row    = out_row_reg;
    assign word_out.dest_pair   = out_pair_reg;
    assign word_out.frame_end   = out_end_reg;

endmodule

@@ rtl/rgb_to_yuyv_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_yuyv_converter
// rgb888 pixel pair to yuyv word converter with vertical frame flip
// ----------------------------------------------------------------------------
// One beat in is a pair of adjacent rgb pixels, one beat out is the yuyv
// word for it, tagged with its destination row (bottom-up, so the frame comes
// out flipped), its pair position within the row, and frame_end on the last
// pair of the frame. The block sustains one pair per clock while the output
// accepts words. From input beat to output beat a pair passes through the
// four-entry queue behind the front, then four math stages (luma products,
// luma sum, chroma products, chroma sum and clamp); the output register is the
// last of these. The position counters in the front advance once per accepted
// pair. Output backpressure freezes the math pipeline; the queue keeps taking
// input until its four entries fill. There is no clearing pass after reset.
// The user must write configuration registers only while the block is idle;
// the block does not enforce this. A write to an unknown index is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rgb_to_yuyv_converter_defines.svh"

module rgb_to_yuyv_converter #(
    parameter int MAX_PAIRS_PER_ROW   = ryc_pkg::MAX_PAIRS_DEFAULT,
    parameter int MAX_ROWS            = ryc_pkg::MAX_ROWS_DEFAULT,
    parameter int COEFF_FRACTION_BITS = ryc_pkg::COEFF_FRAC_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [ryc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ryc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel pairs in, yuyv words out
    ryc_pixel_if.sink                       pixel_in,
    ryc_word_if.source                      word_out
);

    // front to queue
    logic                   push;
    ryc_pkg::job_t          push_job;
    // queue to back
    logic                   pop;
    ryc_pkg::job_t          pop_job;
    ryc_pkg::queue_status_t q_status;
    // coefficients live in the front register file, used by the back
    ryc_pkg::coeff_t        coeff;

    // front: register file, row and pair counters, flip of the row number
    ryc_front #(
        .MAX_PAIRS_PER_ROW (MAX_PAIRS_PER_ROW),
        .MAX_ROWS          (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pixel_in),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job),
        .coeff     (coeff)
    );

    // queue: decouples input acceptance from output backpressure
    ryc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    // back: fixed-point color math and the output register
    ryc_back #(
        .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .coeff    (coeff),
        .q_status (q_status),
        .pop      (pop),
        .pop_job  (pop_job),
        .word_out (word_out)
    );

    // the back never pops an empty queue
    `RYC_ASSERT_IMP(a_pop_not_empty, pop, !q_status.empty, "pop from empty queue")
    // the front never pushes into a full queue
    `RYC_ASSERT_IMP(a_push_not_full, push, !q_status.full, "push into full queue")
    // a lone push leaves the queue holding something
    `RYC_ASSERT_NXT(a_push_fills, push && !pop, !q_status.empty, "pushed entry lost")
    // the last pair of the frame lands on the bottom-up row zero
    `RYC_ASSERT_IMP(a_end_row_zero, word_out.valid && word_out.frame_end,
        word_out.dest_row == '0, "frame end off row zero")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rgb888 pair to yuyv converter
// ----------------------------------------------------------------------------
// Drives pixel pairs on the input channel and predicts every yuyv word in
// step, from a local copy of the coefficient and geometry registers and of
// the pair and row position counters. A monitor compares each output beat
// with the oldest pending prediction, field by field. Directed tests cover
// reset values, clamping at both ends, zero and oversized geometry and a
// frame shrunk mid-way; random phases cover the rest, with both sides
// idling at random and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC         = ryc_pkg::COEFF_FRAC_DEFAULT;
    localparam int PIPE_LATENCY = 5;
    localparam int TIMEOUT_NS   = 1_000_000;
    // index 7 has no register behind it
    localparam logic [ryc_pkg::CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd7;

    typedef struct packed {
        logic [ryc_pkg::PIX_W-1:0]      luma_first;
        logic [ryc_pkg::PIX_W-1:0]      chroma_blue;
        logic [ryc_pkg::PIX_W-1:0]      luma_second;
        logic [ryc_pkg::PIX_W-1:0]      chroma_red;
        logic [ryc_pkg::ROW_OUT_W-1:0]  dest_row;
        logic [ryc_pkg::PAIR_OUT_W-1:0] dest_pair;
        logic                           frame_end;
    } yuyv_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [ryc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ryc_pkg::CFG_DATA_W-1:0]  cfg_data;

    ryc_pixel_if pix_bus ();
    ryc_word_if  word_bus ();

    rgb_to_yuyv_converter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pix_bus),
        .word_out  (word_bus)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // local copy of the register file
    logic [ryc_pkg::PAIRS_REG_W-1:0]    pairs_reg;
    logic [ryc_pkg::ROWS_REG_W-1:0]     rows_reg;
    logic signed [ryc_pkg::COEFF_W-1:0] red_weight;
    logic signed [ryc_pkg::COEFF_W-1:0] green_weight;
    logic signed [ryc_pkg::COEFF_W-1:0] blue_weight;
    logic signed [ryc_pkg::COEFF_W-1:0] blue_gain;
    logic signed [ryc_pkg::COEFF_W-1:0] red_gain;

    // local copy of the position counters
    logic [ryc_pkg::PAIR_OUT_W-1:0] pair_pos;
    logic [ryc_pkg::ROW_OUT_W-1:0]  row_pos;

    // words predicted but not yet seen at the output
    yuyv_word_t pending_words[$];

    int  pairs_sent      = 0;
    int  words_checked   = 0;
    int  frame_ends_seen = 0;
    int  settings_loaded = 0;
    int  mismatches      = 0;
    bit  src_gaps        = 1'b1;
    bit  sink_gaps       = 1'b1;
    int  hold_off_left   = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic int geometry_limit(input int reg_val, input int max_val);
        if (reg_val == 0)
            return 1;
        if (reg_val > max_val)
            return max_val;
        return reg_val;
    endfunction

    function automatic logic [ryc_pkg::PIX_W-1:0] clamp_byte(input longint x);
        if (x < 0)
            return '0;
        if (x > 255)
            return '1;
        return ryc_pkg::PIX_W'(x);
    endfunction

    // unclamped luma, arithmetic shift of the exact weighted sum
    function automatic longint luma_of(input ryc_pkg::rgb_t px);
        longint acc;
        acc = longint'(px.red) * longint'(red_weight)
            + longint'(px.green) * longint'(green_weight)
            + longint'(px.blue) * longint'(blue_weight);
        return acc >>> FRAC;
    endfunction

    // works out the word for one accepted pair and moves the counters on
    task automatic convert_pair(input ryc_pkg::rgb_t a, input ryc_pkg::rgb_t b);
        longint     y0;
        longint     y1;
        longint     u;
        longint     v;
        int         plim;
        int         rlim;
        bit         row_last;
        bit         frame_last;
        yuyv_word_t w;
        y0 = luma_of(a);
        y1 = luma_of(b);
        u  = ((((longint'(a.blue) - y0) + (longint'(b.blue) - y1)) * longint'(blue_gain))
             >>> (FRAC + 1)) + ryc_pkg::CHROMA_OFFSET;
        v  = ((((longint'(a.red) - y0) + (longint'(b.red) - y1)) * longint'(red_gain))
             >>> (FRAC + 1)) + ryc_pkg::CHROMA_OFFSET;
        plim = geometry_limit(int'(pairs_reg), ryc_pkg::MAX_PAIRS_DEFAULT);
        rlim = geometry_limit(int'(rows_reg), ryc_pkg::MAX_ROWS_DEFAULT);
        // a counter past a lowered limit counts as sitting on the last place
        row_last   = int'(pair_pos) >= plim - 1;
        frame_last = int'(row_pos) >= rlim - 1;
        w.luma_first  = clamp_byte(y0);
        w.chroma_blue = clamp_byte(u);
        w.luma_second = clamp_byte(y1);
        w.chroma_red  = clamp_byte(v);
        w.dest_row    = frame_last ? '0 : ryc_pkg::ROW_OUT_W'(rlim - 1 - int'(row_pos));
        w.dest_pair   = pair_pos;
        w.frame_end   = row_last && frame_last;
        pending_words.push_back(w);
        if (row_last)
        begin
            pair_pos = '0;
            row_pos  = frame_last ? '0 : row_pos + ryc_pkg::ROW_OUT_W'(1);
        end
        else
        begin
            pair_pos = pair_pos + ryc_pkg::PAIR_OUT_W'(1);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic ryc_pkg::rgb_t rgb(input int r, input int g, input int b);
        ryc_pkg::rgb_t px;
        px.red   = ryc_pkg::PIX_W'(r);
        px.green = ryc_pkg::PIX_W'(g);
        px.blue  = ryc_pkg::PIX_W'(b);
        return px;
    endfunction

    // mostly uniform, some black, white and grey pixels
    function automatic ryc_pkg::rgb_t random_rgb();
        ryc_pkg::rgb_t px;
        px = ryc_pkg::rgb_t'($urandom);
        case ($urandom_range(7))
            0: px = '0;
            1: px = '1;
            2:
            begin
                px.red  = px.green;
                px.blue = px.green;
            end
            default: ;
        endcase
        return px;
    endfunction

    // a mix of full-range, extreme and moderate weights
    function automatic int random_weight();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            2, 3:    return int'($urandom_range(65535)) - 32768;
            default: return int'($urandom_range(20000)) - 4000;
        endcase
    endfunction

    // one register write; the caller lowers the enable after the last one
    task automatic write_reg(input logic [ryc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ryc_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        case (idx)
            ryc_pkg::REG_PAIRS_PER_ROW:  pairs_reg    = val[ryc_pkg::PAIRS_REG_W-1:0];
            ryc_pkg::REG_ROWS_PER_FRAME: rows_reg     = val[ryc_pkg::ROWS_REG_W-1:0];
            ryc_pkg::REG_LUMA_RED:       red_weight   = val;
            ryc_pkg::REG_LUMA_GREEN:     green_weight = val;
            ryc_pkg::REG_LUMA_BLUE:      blue_weight  = val;
            ryc_pkg::REG_BLUE_DIFF:      blue_gain    = val;
            ryc_pkg::REG_RED_DIFF:       red_gain     = val;
            default: ;
        endcase
    endtask

    // full register set plus a write to the unused index, which must be dropped
    task automatic load_config(input int pairs, input int rows, input int wr,
                               input int wg, input int wb, input int gb,
                               input int gr);
        write_reg(ryc_pkg::REG_PAIRS_PER_ROW, ryc_pkg::CFG_DATA_W'(pairs));
        write_reg(ryc_pkg::REG_ROWS_PER_FRAME, ryc_pkg::CFG_DATA_W'(rows));
        write_reg(ryc_pkg::REG_LUMA_RED, ryc_pkg::CFG_DATA_W'(wr));
        write_reg(ryc_pkg::REG_LUMA_GREEN, ryc_pkg::CFG_DATA_W'(wg));
        write_reg(ryc_pkg::REG_LUMA_BLUE, ryc_pkg::CFG_DATA_W'(wb));
        write_reg(ryc_pkg::REG_BLUE_DIFF, ryc_pkg::CFG_DATA_W'(gb));
        write_reg(ryc_pkg::REG_RED_DIFF, ryc_pkg::CFG_DATA_W'(gr));
        write_reg(UNUSED_INDEX, ryc_pkg::CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // entered and left just after a falling edge; valid stays high on return
    task automatic send_pair(input ryc_pkg::rgb_t a, input ryc_pkg::rgb_t b);
        while (src_gaps && $urandom_range(99) < 20)
        begin
            pix_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pix_bus.valid        <= 1'b1;
        pix_bus.red_first    <= a.red;
        pix_bus.green_first  <= a.green;
        pix_bus.blue_first   <= a.blue;
        pix_bus.red_second   <= b.red;
        pix_bus.green_second <= b.green;
        pix_bus.blue_second  <= b.blue;
        @(posedge clk);
        while (!pix_bus.ready)
            @(posedge clk);
        convert_pair(a, b);
        pairs_sent++;
        @(negedge clk);
    endtask

    // drop valid, let every predicted word come out, then let the pipe settle
    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 3) @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pair(random_rgb(), random_rgb());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset geometry and coefficients, counters from zero
    task automatic test_reset_values();
        send_pair(rgb(0, 0, 0), rgb(255, 255, 255));
        send_pair(rgb(255, 255, 255), rgb(0, 0, 0));
        send_pair(rgb(255, 0, 0), rgb(0, 0, 255));
        send_pair(rgb(0, 255, 0), rgb(255, 0, 255));
        send_pair(rgb(170, 85, 170), rgb(85, 170, 85));
        send_pair(rgb(0, 0, 255), rgb(0, 0, 255));
        send_pair(rgb(255, 0, 0), rgb(255, 0, 0));
        send_pair(rgb(128, 128, 128), rgb(1, 254, 127));
    endtask

    // saturating weights push luma and chroma past both clamp limits;
    // negative luma must still feed the chroma sums unclamped
    task automatic test_clamp_limits();
        wait_idle();
        load_config(2, 2, 32767, 32767, 32767, -32768, 32767);
        send_pair(rgb(0, 0, 0), rgb(255, 255, 255));
        send_pair(rgb(255, 255, 255), rgb(0, 0, 0));
        send_pair(rgb(255, 0, 0), rgb(0, 0, 255));
        send_pair(rgb(0, 255, 0), rgb(128, 128, 128));
        wait_idle();
        load_config(2, 2, -32768, -32768, -32768, 32767, -32768);
        send_pair(rgb(0, 0, 0), rgb(255, 255, 255));
        send_pair(rgb(255, 255, 255), rgb(0, 0, 0));
        send_pair(rgb(255, 0, 0), rgb(0, 0, 255));
        send_pair(rgb(0, 255, 0), rgb(128, 128, 128));
    endtask

    // zero geometry acts as one, oversized acts as the maximum
    task automatic test_degenerate_geometry();
        wait_idle();
        load_config(0, 0, ryc_pkg::LUMA_RED_RESET, ryc_pkg::LUMA_GREEN_RESET,
                    ryc_pkg::LUMA_BLUE_RESET, ryc_pkg::BLUE_DIFF_RESET,
                    ryc_pkg::RED_DIFF_RESET);
        send_random(3);
        wait_idle();
        load_config(1, 3, ryc_pkg::LUMA_RED_RESET, ryc_pkg::LUMA_GREEN_RESET,
                    ryc_pkg::LUMA_BLUE_RESET, ryc_pkg::BLUE_DIFF_RESET,
                    ryc_pkg::RED_DIFF_RESET);
        send_random(3);
        wait_idle();
        load_config(600, 0, ryc_pkg::LUMA_RED_RESET, ryc_pkg::LUMA_GREEN_RESET,
                    ryc_pkg::LUMA_BLUE_RESET, ryc_pkg::BLUE_DIFF_RESET,
                    ryc_pkg::RED_DIFF_RESET);
        send_random(2);
    endtask

    // shrink the frame while the counters sit past the new limits
    task automatic test_lowered_geometry();
        wait_idle();
        load_config(30, 12, random_weight(), random_weight(), random_weight(),
                    random_weight(), random_weight());
        send_random(100);
        wait_idle();
        load_config(5, 2, random_weight(), random_weight(), random_weight(),
                    random_weight(), random_weight());
        send_random(30);
        wait_idle();
        load_config(40, 9, random_weight(), random_weight(), random_weight(),
                    random_weight(), random_weight());
        send_random(130);
        // only the row count drops this time
        wait_idle();
        load_config(40, 1, random_weight(), random_weight(), random_weight(),
                    random_weight(), random_weight());
        send_random(20);
    endtask

    // largest frame, no idling on either side: dest_pair runs to its top
    task automatic test_full_size_frame();
        wait_idle();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        load_config(1023, 2047, ryc_pkg::LUMA_RED_RESET, ryc_pkg::LUMA_GREEN_RESET,
                    ryc_pkg::LUMA_BLUE_RESET, ryc_pkg::BLUE_DIFF_RESET,
                    ryc_pkg::RED_DIFF_RESET);
        send_random(530);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // long output stall while input keeps coming, so the queue fills up
    task automatic test_output_stall();
        wait_idle();
        load_config(7, 3, random_weight(), random_weight(), random_weight(),
                    random_weight(), random_weight());
        src_gaps      = 1'b0;
        hold_off_left = 80;
        send_random(120);
        src_gaps = 1'b1;
    endtask

    // many short frames under random settings
    task automatic test_random_frames();
        int pairs;
        int rows;
        repeat (10)
        begin
            case ($urandom_range(9))
                0:       pairs = 0;
                1:       pairs = $urandom_range(9, 40);
                default: pairs = $urandom_range(1, 8);
            endcase
            rows = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            wait_idle();
            load_config(pairs, rows, random_weight(), random_weight(),
                        random_weight(), random_weight(), random_weight());
            send_random(80);
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ready is driven at the falling edge; the hold-off counts whole cycles
    initial
    begin
        word_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                word_bus.ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                word_bus.ready <= !(sink_gaps && $urandom_range(99) < 20);
            end
        end
    end

    // every output beat against the oldest pending word
    always @(posedge clk)
    begin
        yuyv_word_t want;
        if (rst_n && word_bus.valid && word_bus.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("output beat with no word pending: row %0d pair %0d",
                       word_bus.dest_row, word_bus.dest_pair);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("luma_first", int'(want.luma_first),
                            int'(word_bus.luma_first));
                check_field("chroma_blue", int'(want.chroma_blue),
                            int'(word_bus.chroma_blue));
                check_field("luma_second", int'(want.luma_second),
                            int'(word_bus.luma_second));
                check_field("chroma_red", int'(want.chroma_red),
                            int'(word_bus.chroma_red));
                check_field("dest_row", int'(want.dest_row), int'(word_bus.dest_row));
                check_field("dest_pair", int'(want.dest_pair), int'(word_bus.dest_pair));
                check_field("frame_end", int'(want.frame_end), int'(word_bus.frame_end));
                words_checked++;
                if (want.frame_end)
                    frame_ends_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        pix_bus.valid        = 1'b0;
        pix_bus.red_first    = '0;
        pix_bus.green_first  = '0;
        pix_bus.blue_first   = '0;
        pix_bus.red_second   = '0;
        pix_bus.green_second = '0;
        pix_bus.blue_second  = '0;

        // register and counter state after reset
        pairs_reg    = ryc_pkg::PAIRS_REG_W'(ryc_pkg::PAIRS_RESET);
        rows_reg     = ryc_pkg::ROWS_REG_W'(ryc_pkg::ROWS_RESET);
        red_weight   = ryc_pkg::COEFF_W'(ryc_pkg::LUMA_RED_RESET);
        green_weight = ryc_pkg::COEFF_W'(ryc_pkg::LUMA_GREEN_RESET);
        blue_weight  = ryc_pkg::COEFF_W'(ryc_pkg::LUMA_BLUE_RESET);
        blue_gain    = ryc_pkg::COEFF_W'(ryc_pkg::BLUE_DIFF_RESET);
        red_gain     = ryc_pkg::COEFF_W'(ryc_pkg::RED_DIFF_RESET);
        pair_pos     = '0;
        row_pos      = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_clamp_limits();
        test_degenerate_geometry();
        test_lowered_geometry();
        test_full_size_frame();
        test_output_stall();
        test_random_frames();

        // drain, then stay quiet a while longer to catch any stray beat
        wait_idle();
        repeat (4 * PIPE_LATENCY) @(negedge clk);

        $display("sent %0d pixel pairs under %0d register settings, checked %0d words",
                 pairs_sent, settings_loaded + 1, words_checked);
        $display("%0d frame ends seen, %0d mismatches", frame_ends_seen, mismatches);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hung handshake guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d words still pending", pending_words.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
